@@ src/seeds_pkg.sv @@
`default_nettype none

package seeds_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 1024;
    localparam int BIRTH_COUNT = 2;

    localparam int GRID_WIDTH_BITS  = 7;
    localparam int GRID_HEIGHT_BITS = 11;
    localparam int CFG_DATA_BITS    = 11;
    localparam int CFG_INDEX_BITS   = 1;

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int W_BITS     = $clog2(MAX_WIDTH + 1);
    localparam int H_BITS     = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT + 3);
    localparam int STORE_BITS = 2;
    localparam int COUNT_BITS = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = CFG_INDEX_BITS'(1);

    localparam logic [GRID_WIDTH_BITS-1:0]  RESET_GRID_WIDTH  = GRID_WIDTH_BITS'(64);
    localparam logic [GRID_HEIGHT_BITS-1:0] RESET_GRID_HEIGHT = GRID_HEIGHT_BITS'(64);

    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic                keep;
        logic                col_zero;
        logic                emit;
        logic                top;
        logic                bottom;
        logic                left_edge;
        logic                right_edge;
        logic                last;
    } cell_pos_t;

endpackage

`default_nettype wire

@@ src/seeds_cell_if.sv @@
`default_nettype none

interface seeds_cell_if;
    logic valid;
    logic ready;
    logic alive;

    modport source (output valid, output alive, input ready);
    modport sink (input valid, input alive, output ready);
endinterface

`default_nettype wire

@@ src/seeds_result_if.sv @@
`default_nettype none

interface seeds_result_if;
    logic valid;
    logic ready;
    logic next_alive;
    logic frame_last;

    modport source (output valid, output next_alive, output frame_last, input ready);
    modport sink (input valid, input next_alive, input frame_last, output ready);
endinterface

`default_nettype wire

@@ src/seeds_ram.sv @@
`default_nettype none

module seeds_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/seeds_raster.sv @@
`default_nettype none

module seeds_raster
    import seeds_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                      advance,
    output      cell_pos_t                 pos
);

    logic [GRID_WIDTH_BITS-1:0]  grid_width_reg;
    logic [GRID_HEIGHT_BITS-1:0] grid_height_reg;
    logic [COL_BITS-1:0]         col_reg, col_next;
    logic [ROW_BITS-1:0]         row_reg, row_next;

    logic [W_BITS-1:0]   w_eff, w_last, ec, col_inc;
    logic [H_BITS-1:0]   h_eff;
    logic [ROW_BITS-1:0] h_ext, h_plus1, er, row_a;
    logic [COL_BITS-1:0] col_a;
    logic                c_zero, row_ok;

    always_comb
    begin
        if (grid_width_reg == '0)
            w_eff = W_BITS'(1);
        else if (32'(grid_width_reg) > 32'(MAX_WIDTH))
            w_eff = W_BITS'(MAX_WIDTH);
        else
            w_eff = W_BITS'(grid_width_reg);

        if (grid_height_reg == '0)
            h_eff = H_BITS'(1);
        else if (32'(grid_height_reg) > 32'(MAX_HEIGHT))
            h_eff = H_BITS'(MAX_HEIGHT);
        else
            h_eff = H_BITS'(grid_height_reg);
    end

    assign h_ext   = ROW_BITS'(h_eff);
    assign h_plus1 = h_ext + ROW_BITS'(1);
    assign w_last  = w_eff - W_BITS'(1);

    // wrap onto the current geometry before use
    always_comb
    begin
        col_a = col_reg;
        row_a = row_reg;
        if (W_BITS'(col_reg) >= w_eff)
        begin
            col_a = '0;
            row_a = row_reg + ROW_BITS'(1);
        end
        if (row_a > h_plus1)
        begin
            row_a = '0;
            col_a = '0;
        end
    end

    assign c_zero  = (col_a == '0);
    assign er      = c_zero ? row_a - ROW_BITS'(2) : row_a - ROW_BITS'(1);
    assign ec      = c_zero ? w_last : W_BITS'(col_a) - W_BITS'(1);
    assign row_ok  = c_zero ? (row_a >= ROW_BITS'(2)) : (row_a != '0);
    assign col_inc = W_BITS'(col_a) + W_BITS'(1);

    always_comb
    begin
        pos.col        = col_a;
        pos.keep       = (row_a < h_ext);
        pos.col_zero   = c_zero;
        pos.emit       = row_ok && (er < h_ext);
        pos.top        = (er == '0);
        pos.bottom     = (er == h_ext - ROW_BITS'(1));
        pos.left_edge  = (ec == '0);
        pos.right_edge = (ec == w_last);
        pos.last       = pos.bottom && pos.right_edge;
    end

    always_comb
    begin
        if (row_a >= h_plus1)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = row_a + ROW_BITS'(1);
        end
        else
        begin
            col_next = col_inc[COL_BITS-1:0];
            row_next = row_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= RESET_GRID_WIDTH;
            grid_height_reg <= RESET_GRID_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GRID_WIDTH_BITS-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[GRID_HEIGHT_BITS-1:0];
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/seeds_automaton_generation.sv @@
`default_nettype none

// channel   dir  payload                  role
// in_ch     in   alive                    raster cells, then flush requests
// out_ch    out  next_alive, frame_last   next generation, one per cell
// cfg       in   cfg_index, cfg_data      grid_width, grid_height
//
// one request per cycle while out_ch does not stall; a result is loaded into the
// output register from the window stage, which holds its request after acceptance
// reset clears positions, window and store valid bits at once, no sweep
// a stall on out_ch holds the window stage and drops in_ch ready in the same
// cycle once that stage holds a request

module seeds_automaton_generation
    import seeds_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    seeds_cell_if.sink                     in_ch,
    seeds_result_if.source                 out_ch,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cell_pos_t pos;
    logic      accept, s1_go;

    logic      s1_valid_reg, s1_valid_next;
    cell_pos_t s1_pos_reg;
    logic      s1_alive_reg;
    logic      bypass_reg;
    logic [STORE_BITS-1:0] bypass_data_reg;
    logic      entry_valid_reg;
    logic [MAX_WIDTH-1:0]  store_valid_reg;

    logic [8:0] window_reg, window_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_alive_reg, out_last_reg;

    logic [STORE_BITS-1:0] ram_q, stored, wdata;
    logic [2:0] newcol, left, centre, right, rowmask;
    logic [COUNT_BITS-1:0] n;
    logic       born;

    assign s1_go        = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || s1_go;
    assign accept       = in_ch.valid && in_ch.ready;

    seeds_raster u_raster (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .pos       (pos)
    );

    // bit 0 two rows back, bit 1 one row back
    seeds_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_pos_reg.col),
        .wdata (wdata),
        .re    (accept),
        .raddr (pos.col),
        .rdata (ram_q)
    );

    always_comb
    begin
        if (bypass_reg)
            stored = bypass_data_reg;
        else if (entry_valid_reg)
            stored = ram_q;
        else
            stored = '0;
    end

    assign wdata       = {s1_alive_reg, stored[1]};
    assign newcol      = {s1_alive_reg, stored[1], stored[0]};
    assign window_next = {newcol, window_reg[8:3]};

    always_comb
    begin
        if (s1_pos_reg.col_zero)
        begin
            left   = window_reg[5:3];
            centre = window_reg[8:6];
            right  = '0;
        end
        else
        begin
            left   = window_next[2:0];
            centre = window_next[5:3];
            right  = window_next[8:6];
        end
        rowmask = {!s1_pos_reg.bottom, 1'b1, !s1_pos_reg.top};
        if (s1_pos_reg.left_edge)
            left = '0;
        if (s1_pos_reg.right_edge)
            right = '0;
        left   = left & rowmask;
        right  = right & rowmask;
        centre = centre & rowmask;
        n = COUNT_BITS'(left[0]) + COUNT_BITS'(left[1]) + COUNT_BITS'(left[2])
          + COUNT_BITS'(right[0]) + COUNT_BITS'(right[1]) + COUNT_BITS'(right[2])
          + COUNT_BITS'(centre[0]) + COUNT_BITS'(centre[2]);
        born = !centre[1] && (n == COUNT_BITS'(BIRTH_COUNT));
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_go && s1_pos_reg.emit)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            window_reg      <= '0;
            store_valid_reg <= '0;
            bypass_reg      <= 1'b0;
            entry_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_go)
            begin
                window_reg                      <= window_next;
                store_valid_reg[s1_pos_reg.col] <= 1'b1;
            end
            if (accept)
            begin
                bypass_reg      <= s1_go && (s1_pos_reg.col == pos.col);
                entry_valid_reg <= store_valid_reg[pos.col];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg      <= pos;
            s1_alive_reg    <= in_ch.alive && pos.keep;
            bypass_data_reg <= wdata;
        end
        if (s1_go && s1_pos_reg.emit)
        begin
            out_alive_reg <= born;
            out_last_reg  <= s1_pos_reg.last;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.next_alive = out_alive_reg;
    assign out_ch.frame_last = out_last_reg;

endmodule

`default_nettype wire

@@ test/seeds_automaton_generation_tb.sv @@
`default_nettype none

module seeds_automaton_generation_tb
    import seeds_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_CELLS   = 2000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned FRAME_CELL_CAP = 1200;
    localparam int unsigned HOLD_CYCLES    = 150;
    localparam int unsigned REPORT_LIMIT   = 100;
    localparam int          DIRECTED_ROWS  = 36;

    typedef struct packed {
        logic next_alive;
        logic frame_last;
    } generation_t;

    typedef enum logic {ROW_CELL, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
        logic                      live;
        logic                      typed;
        generation_t               want;
    } stim_row_t;

    typedef enum logic [1:0] {FLOW_FREE, FLOW_MOSTLY, FLOW_PERIODIC, FLOW_SPARSE} flow_mode_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    seeds_cell_if   cell_ch ();
    seeds_result_if result_ch ();

    seeds_automaton_generation DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (cell_ch),
        .out_ch    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic                        store_upper [MAX_WIDTH];
    logic                        store_middle [MAX_WIDTH];
    logic [8:0]                  window_cells;
    int unsigned                 col_pos;
    int unsigned                 row_pos;
    logic [GRID_WIDTH_BITS-1:0]  width_reg;
    logic [GRID_HEIGHT_BITS-1:0] height_reg;

    generation_t expected_cells [$];
    int unsigned cells_sent;
    int unsigned frame_ends;
    int unsigned results_seen;
    int unsigned failures;
    int unsigned burst_left;

    stim_row_t directed_rows [DIRECTED_ROWS];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned cols_of(input logic [GRID_WIDTH_BITS-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_WIDTH)
            return MAX_WIDTH;
        return 32'(raw);
    endfunction

    function automatic int unsigned rows_of(input logic [GRID_HEIGHT_BITS-1:0] raw);
        if (raw == 0)
            return 1;
        if (raw > MAX_HEIGHT)
            return MAX_HEIGHT;
        return 32'(raw);
    endfunction

    function automatic bit step_generation(input logic live, output generation_t outcome);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned er;
        int unsigned ec;
        int unsigned n;
        logic        v;
        logic [2:0]  newcol;
        logic [2:0]  left;
        logic [2:0]  centre;
        logic [2:0]  right;
        logic [2:0]  rowmask;
        bit          emit;
        bit          produced;

        w = cols_of(width_reg);
        h = rows_of(height_reg);
        emit = 1'b0;
        produced = 1'b0;
        er = 0;
        ec = 0;
        left = '0;
        centre = '0;
        right = '0;
        outcome = '0;

        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos > h + 1)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        c = col_pos;
        r = row_pos;

        // flush requests enter as dead cells
        v = (r < h) ? live : 1'b0;
        newcol = {v, store_middle[c], store_upper[c]};
        store_upper[c] = store_middle[c];
        store_middle[c] = v;

        if (c == 0)
        begin
            if (r >= 2)
            begin
                er = r - 2;
                ec = w - 1;
                left = window_cells[5:3];
                centre = window_cells[8:6];
                emit = 1'b1;
            end
            window_cells = {newcol, window_cells[8:3]};
        end
        else
        begin
            window_cells = {newcol, window_cells[8:3]};
            if (r >= 1)
            begin
                er = r - 1;
                ec = c - 1;
                left = window_cells[2:0];
                centre = window_cells[5:3];
                right = window_cells[8:6];
                emit = 1'b1;
            end
        end

        if (emit && er < h)
        begin
            rowmask = 3'b111;
            if (er == 0)
                rowmask[0] = 1'b0;
            if (er == h - 1)
                rowmask[2] = 1'b0;
            if (ec == 0)
                left = '0;
            if (ec == w - 1)
                right = '0;
            left &= rowmask;
            right &= rowmask;
            centre &= rowmask;
            n = $countones(left) + $countones(right) + centre[0] + centre[2];
            outcome.next_alive = !centre[1] && n == BIRTH_COUNT;
            outcome.frame_last = er == h - 1 && ec == w - 1;
            produced = 1'b1;
        end

        if (r >= h + 1)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        else
        begin
            col_pos = c + 1;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos = r + 1;
            end
        end
        return produced;
    endfunction

    function automatic stim_row_t put_reg(input logic [CFG_INDEX_BITS-1:0] index,
                                          input logic [CFG_DATA_BITS-1:0] data);
        return '{ROW_WRITE, index, data, 1'b0, 1'b0, '0};
    endfunction

    function automatic stim_row_t put_cell(input logic live);
        return '{ROW_CELL, '0, '0, live, 1'b0, '0};
    endfunction

    function automatic stim_row_t put_want(input logic live, input logic nxt, input logic last);
        return '{ROW_CELL, '0, '0, live, 1'b1, '{nxt, last}};
    endfunction

    task automatic send_cell(input logic live, input logic typed = 1'b0,
                             input generation_t typed_want = '0);
        generation_t outcome;
        int unsigned gap;

        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 30);
            gap = $urandom_range(1, 6);
            cell_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        cell_ch.valid <= 1'b1;
        cell_ch.alive <= live;
        do
            @(posedge clk);
        while (!cell_ch.ready);
        cells_sent++;
        if (step_generation(live, outcome))
        begin
            if (outcome.frame_last)
                frame_ends++;
            if (!typed)
                expected_cells.push_back(outcome);
        end
        if (typed)
            expected_cells.push_back(typed_want);
    endtask

    // sender holds off until every result is back and the pipeline is empty
    task automatic wait_idle();
        cell_ch.valid <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] data);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == REG_GRID_WIDTH)
            width_reg = data[GRID_WIDTH_BITS-1:0];
        else if (index == REG_GRID_HEIGHT)
            height_reg = data[GRID_HEIGHT_BITS-1:0];
    endtask

    always @(posedge clk)
    begin
        generation_t seen;
        generation_t want;

        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            seen = '{result_ch.next_alive, result_ch.frame_last};
            results_seen++;
            if (expected_cells.size() == 0)
            begin
                if (failures < REPORT_LIMIT)
                    $display("%0t: unexpected result, next_alive %b frame_last %b",
                             $time, seen.next_alive, seen.frame_last);
                failures++;
            end
            else
            begin
                want = expected_cells.pop_front();
                if (seen.next_alive !== want.next_alive)
                begin
                    if (failures < REPORT_LIMIT)
                        $display("%0t: next_alive expected %b, got %b",
                                 $time, want.next_alive, seen.next_alive);
                    failures++;
                end
                if (seen.frame_last !== want.frame_last)
                begin
                    if (failures < REPORT_LIMIT)
                        $display("%0t: frame_last expected %b, got %b",
                                 $time, want.frame_last, seen.frame_last);
                    failures++;
                end
            end
        end
    end

    // receiver: shifting stall patterns, plus long hold-offs to back up the input
    initial
    begin
        flow_mode_t  mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned next_hold_at;
        int unsigned tick;

        mode = FLOW_FREE;
        mode_left = 0;
        hold_left = 0;
        next_hold_at = 300;
        tick = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_left != 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (results_seen >= next_hold_at)
            begin
                hold_left = HOLD_CYCLES;
                next_hold_at += 1200;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = flow_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    FLOW_FREE:     result_ch.ready <= 1'b1;
                    FLOW_MOSTLY:   result_ch.ready <= $urandom_range(0, 9) < 7;
                    FLOW_PERIODIC: result_ch.ready <= (tick % 3) != 0;
                    default:       result_ch.ready <= $urandom_range(0, 9) < 3;
                endcase
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int unsigned                 random_goal;
        int unsigned                 density;
        int unsigned                 frame_goal;
        logic [GRID_WIDTH_BITS-1:0]  w_new;
        logic [GRID_HEIGHT_BITS-1:0] h_new;
        bit                          do_w;
        bit                          do_h;

        rst_n <= 1'b0;
        cell_ch.valid <= 1'b0;
        cell_ch.alive <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_GRID_WIDTH;
        cfg_data <= '0;

        foreach (store_upper[i])
        begin
            store_upper[i] = 1'b0;
            store_middle[i] = 1'b0;
        end
        window_cells = '0;
        col_pos = 0;
        row_pos = 0;
        width_reg = RESET_GRID_WIDTH;
        height_reg = RESET_GRID_HEIGHT;
        cells_sent = 0;
        frame_ends = 0;
        results_seen = 0;
        failures = 0;
        burst_left = 0;

        directed_rows = '{
            // zero sizes taken as a single cell; flush values ignored
            put_reg(REG_GRID_WIDTH, 11'd0),
            put_reg(REG_GRID_HEIGHT, 11'd0),
            put_cell(1'b1),
            put_cell(1'b1),
            put_want(1'b1, 1'b0, 1'b1),
            // one column: a dead cell between two live ones is born
            put_reg(REG_GRID_WIDTH, 11'd1),
            put_reg(REG_GRID_HEIGHT, 11'd3),
            put_cell(1'b1),
            put_cell(1'b0),
            put_want(1'b1, 1'b0, 1'b0),
            put_want(1'b1, 1'b1, 1'b0),
            put_want(1'b1, 1'b0, 1'b1),
            // oversize registers, upper data bits set on the width write
            put_reg(REG_GRID_WIDTH, 11'h7FF),
            put_reg(REG_GRID_HEIGHT, 11'd2047),
            put_cell(1'b1),
            put_cell(1'b1),
            put_cell(1'b0),
            put_cell(1'b1),
            put_cell(1'b1),
            // width shrunk mid-frame, column wraps to the next row
            put_reg(REG_GRID_WIDTH, 11'd3),
            put_reg(REG_GRID_HEIGHT, 11'd2),
            put_cell(1'b0),
            put_cell(1'b1),
            put_cell(1'b1),
            put_cell(1'b0),
            put_reg(REG_GRID_WIDTH, 11'd1),
            put_reg(REG_GRID_HEIGHT, 11'd8),
            put_cell(1'b1),
            put_cell(1'b0),
            put_cell(1'b1),
            put_cell(1'b1),
            put_cell(1'b0),
            // height shrunk mid-frame, frame restarts at the top
            put_reg(REG_GRID_HEIGHT, 11'd2),
            put_cell(1'b1),
            put_cell(1'b0),
            put_cell(1'b1)
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
                write_reg(directed_rows[i].index, directed_rows[i].data);
            else
                send_cell(directed_rows[i].live, directed_rows[i].typed, directed_rows[i].want);
        end

        random_goal = cells_sent + RANDOM_CELLS;
        while (cells_sent < random_goal)
        begin
            case ($urandom_range(0, 9))
                0:       w_new = '0;
                1:       w_new = GRID_WIDTH_BITS'($urandom_range(MAX_WIDTH, 127));
                2:       w_new = GRID_WIDTH_BITS'($urandom_range(11, MAX_WIDTH - 1));
                default: w_new = GRID_WIDTH_BITS'($urandom_range(1, 10));
            endcase
            case ($urandom_range(0, 19))
                0:       h_new = '0;
                1:       h_new = GRID_HEIGHT_BITS'($urandom_range(MAX_HEIGHT, 2047));
                2:       h_new = GRID_HEIGHT_BITS'($urandom_range(9, 300));
                default: h_new = GRID_HEIGHT_BITS'($urandom_range(1, 8));
            endcase
            do_w = $urandom_range(0, 4) != 0;
            do_h = $urandom_range(0, 4) != 0;
            if (!do_w)
                w_new = width_reg;
            if (!do_h)
                h_new = height_reg;
            // keep whole frames short
            if (cols_of(w_new) * rows_of(h_new) > FRAME_CELL_CAP)
            begin
                h_new = GRID_HEIGHT_BITS'(FRAME_CELL_CAP / cols_of(w_new));
                do_h = 1'b1;
            end
            if (do_w)
                write_reg(REG_GRID_WIDTH, {4'($urandom_range(0, 15)), w_new});
            if (do_h)
                write_reg(REG_GRID_HEIGHT, h_new);

            density = ($urandom_range(0, 5) == 0) ? 6 : $urandom_range(1, 4);
            if ($urandom_range(0, 4) != 0)
            begin
                // run on to the end of the current frame and then whole frames
                frame_goal = frame_ends + $urandom_range(1, 3);
                while (frame_ends < frame_goal)
                    send_cell($urandom_range(0, 7) < density);
            end
            else
            begin
                // broken off mid-frame before the next reconfiguration
                repeat ($urandom_range(1, 2 * cols_of(width_reg) + 6))
                    send_cell($urandom_range(0, 7) < density);
            end
        end

        wait_idle();
        repeat (16) @(posedge clk);
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
src/seeds_pkg.sv
src/seeds_cell_if.sv
src/seeds_result_if.sv
src/seeds_ram.sv
src/seeds_raster.sv
src/seeds_automaton_generation.sv
test/seeds_automaton_generation_tb.sv
